// ----- hdl/lrc_pkg.sv -----
// lrc_pkg: shared types and constants for the line fit / correlation block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lrc_pkg;

    // Working word of all second-order arithmetic (wraps modulo 2^64)
    localparam int W64         = 64;
    localparam int HALF        = 32;
    // Slope is Q16.16, correlation numerator shift is 15 + root pre-shift
    localparam int SLOPE_SH    = 16;
    localparam int CORR_SQ_SH  = 12;
    localparam int CORR_DIV_SH = 27;
    localparam int ICPT_SH     = 0;
    localparam int DIV_CNT_W   = 7;
    localparam int QUOT_W      = 32;
    localparam int CORR_W      = 16;

    // Saturation limits on quotient magnitude
    localparam logic [QUOT_W-1:0] LIM_POS32 = 32'h7FFF_FFFF;
    localparam logic [QUOT_W-1:0] LIM_NEG32 = 32'h8000_0000;
    localparam logic [QUOT_W-1:0] LIM_POS16 = 32'h0000_7FFF;
    localparam logic [QUOT_W-1:0] LIM_NEG16 = 32'h0000_8000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_VX  = 2'd1,
        ST_ZERO_VY  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC_XX,
        S_ACC_YY,
        S_ACC_XY,
        S_V_XX1,
        S_V_XX2,
        S_V_YY1,
        S_V_YY2,
        S_V_XY1,
        S_V_XY2,
        S_SLOPE_DIV,
        S_ICPT_MUL,
        S_ICPT_DIV,
        S_SQRT_X,
        S_SQRT_Y,
        S_CORR_MUL,
        S_CORR_DIV,
        S_FIN
    } t_state;

    // Request to the divider: magnitude, divisor, step count, clip limit
    typedef struct packed {
        logic [W64-1:0]       mag;
        logic [W64-1:0]       den;
        logic [DIV_CNT_W-1:0] iters;
        logic [QUOT_W-1:0]    lim;
    } t_div_req;

endpackage

// ----- hdl/lrc_if.sv -----
// lrc_if: valid/ready channel interfaces for points in and fit results out.
// Depends on lrc_pkg.
`timescale 1ns / 1ps

interface lrc_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x_sample;
    logic signed [SAMPLE_BITS-1:0] y_sample;
    logic                          last_point;

    modport source (output valid, x_sample, y_sample, last_point, input ready);
    modport sink   (input valid, x_sample, y_sample, last_point, output ready);
endinterface

interface lrc_out_if import lrc_pkg::*; #(
    parameter int CNT_W = 11
) ();
    logic                     valid;
    logic                     ready;
    logic signed [QUOT_W-1:0] slope;
    logic signed [QUOT_W-1:0] intercept;
    logic signed [CORR_W-1:0] correlation;
    logic [CNT_W-1:0]         point_count;
    logic [1:0]               status;

    modport source (output valid, slope, intercept, correlation, point_count, status,
                    input ready);
    modport sink   (input valid, slope, intercept, correlation, point_count, status,
                    output ready);
endinterface

// ----- hdl/lrc_mul.sv -----
// lrc_mul: low 64 bits of a 64x64 product from one 32x32 multiplier, three passes.
// Depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_mul import lrc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W64-1:0] i_a,
    input  logic [W64-1:0] i_b,
    output logic           o_done,
    output logic [W64-1:0] o_prod
);
    localparam logic [1:0] PH_LL   = 2'd0;
    localparam logic [1:0] PH_LH   = 2'd1;
    localparam logic [1:0] PH_HL   = 2'd2;
    localparam logic [1:0] PH_LAST = 2'd3;

    logic [W64-1:0]  r_a, r_b, r_pp, r_acc;
    logic [1:0]      r_ph;
    logic            r_busy, r_done;
    logic [HALF-1:0] op_a, op_b;
    logic [W64-1:0]  mult;

    // Partial product select: lo*lo, lo*hi, hi*lo
    always_comb begin
        op_a = (r_ph == PH_HL) ? r_a[W64-1:HALF] : r_a[HALF-1:0];
        op_b = (r_ph == PH_LH) ? r_b[W64-1:HALF] : r_b[HALF-1:0];
        mult = op_a * op_b;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_ph   <= PH_LL;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == PH_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: product register, then accumulate the shifted cross terms
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            r_pp <= mult;
            case (r_ph)
                PH_LH:   r_acc <= r_pp;
                PH_HL,
                PH_LAST: r_acc <= r_acc + {r_pp[HALF-1:0], {HALF{1'b0}}};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- hdl/lrc_div.sv -----
// lrc_div: restoring divider, one quotient bit a cycle, floor(mag*2^sh/den) clipped.
// Depends on lrc_pkg (t_div_req).
`timescale 1ns / 1ps

module lrc_div import lrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);
    logic [W64-1:0]       r_num, r_rem, r_den;
    logic [QUOT_W-1:0]    r_lim;
    logic [QUOT_W+1:0]    r_q;
    logic                 r_sat, r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [W64:0]      rem_sh, diff;
    logic              ge, over;
    logic [QUOT_W+1:0] q_nx;

    // One trial subtraction per cycle
    always_comb begin
        rem_sh = {r_rem, r_num[W64-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        q_nx   = {r_q[QUOT_W:0], ge};
        over   = (q_nx > {2'b00, r_lim});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                // divide by zero answers zero at once
                if (i_req.den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (over || r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_req.mag;
            r_den <= i_req.den;
            r_lim <= i_req.lim;
            r_cnt <= i_req.iters;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[W64-2:0], 1'b0};
            r_rem <= ge ? diff[W64-1:0] : rem_sh[W64-1:0];
            r_q   <= q_nx;
            r_sat <= over;
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? r_lim : r_q[QUOT_W-1:0];

endmodule

// ----- hdl/lrc_sqrt.sv -----
// lrc_sqrt: bit-pair integer square root, floor, one result bit a cycle.
// Depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_sqrt import lrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W64-1:0]    i_val,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_root
);
    localparam logic [W64-1:0] BIT_TOP = {2'b01, {(W64-2){1'b0}}};

    logic [W64-1:0] r_v, r_res, r_bit;
    logic           r_busy, r_done;
    logic [W64-1:0] trial;
    logic           ge;

    always_comb begin
        trial = r_res + r_bit;
        ge    = (r_v >= trial);
    end

    // Control: ends on the step in which the marker bit reaches bit 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= BIT_TOP;
        end else if (r_busy) begin
            if (ge) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[QUOT_W-1:0];

endmodule

// ----- hdl/linear_regression_correlation.sv -----
// linear_regression_correlation: streaming least-squares line fit and Pearson
// correlation. Depends on lrc_pkg, lrc_if, lrc_mul, lrc_div, lrc_sqrt.
//
//  channel  dir  transaction                                 handshake
//  i_pt     in   x_sample, y_sample, last_point              valid/ready
//  o_res    out  slope, intercept, correlation, count, status valid/ready
//
// One point at a time: ready only in idle. Each point needs three 64-bit
// products on the shared multiplier before the next accept. A last point adds
// the closing sequence: eight products, up to three divides and two roots,
// before the result register loads. A new set may be accumulated while the
// result waits; the next closing stalls only if the previous result is still
// untaken. Synchronous reset, no clearing pass.
`timescale 1ns / 1ps

module linear_regression_correlation import lrc_pkg::*; #(
    parameter int MAX_POINTS  = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrc_in_if.sink    i_pt,
    lrc_out_if.source o_res
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SX_W  = (SAMPLE_BITS + CNT_W > W64) ? W64 : SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = (2 * SAMPLE_BITS + CNT_W > W64) ? W64 : 2 * SAMPLE_BITS + CNT_W;

    t_state r_state, n_state;
    logic   r_go, n_go;

    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic signed [SX_W-1:0]        r_sx, n_sx, r_sy, n_sy;
    logic signed [SQ_W-1:0]        r_sxx, n_sxx, r_syy, n_syy, r_sxy, n_sxy;
    logic                          r_ovf, n_ovf;
    logic signed [SAMPLE_BITS-1:0] r_xs, n_xs, r_ys, n_ys;
    logic                          r_last, n_last;
    logic [W64-1:0]                r_t, n_t, r_vxx, n_vxx, r_vyy, n_vyy, r_vxy, n_vxy;
    logic signed [QUOT_W-1:0]      r_slope, n_slope, r_icpt, n_icpt;
    logic signed [CORR_W-1:0]      r_corr, n_corr;
    logic [QUOT_W-1:0]             r_rx, n_rx, r_ry, n_ry;

    logic                     r_o_valid, n_o_valid;
    logic signed [QUOT_W-1:0] r_o_slope, n_o_slope, r_o_icpt, n_o_icpt;
    logic signed [CORR_W-1:0] r_o_corr, n_o_corr;
    logic [CNT_W-1:0]         r_o_cnt, n_o_cnt;
    t_status                  r_o_stat, n_o_stat;

    // Shared unit handshakes
    logic              mul_sel, div_sel, sq_sel;
    logic [W64-1:0]    mul_a, mul_b, mul_prod;
    logic              mul_done, div_done, sq_done;
    t_div_req          div_req;
    logic [QUOT_W-1:0] div_quot, div_res, sq_root;
    logic [W64-1:0]    div_dvd, sq_val;
    logic              div_neg, div_corr;
    logic              vxx_pos, vyy_pos;
    logic [W64-1:0]    x64, y64, sx64, sy64, sxx64, syy64, sxy64, n64;

    lrc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go && mul_sel),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    lrc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go && div_sel),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    lrc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go && sq_sel),
        .i_val  (sq_val),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    // Operand views widened to the 64-bit working word (samples and sums sign-extended)
    always_comb begin
        x64     = W64'(r_xs);
        y64     = W64'(r_ys);
        sx64    = W64'(r_sx);
        sy64    = W64'(r_sy);
        sxx64   = W64'(r_sxx);
        syy64   = W64'(r_syy);
        sxy64   = W64'(r_sxy);
        n64     = W64'(r_cnt);
        vxx_pos = !r_vxx[W64-1] && (r_vxx != '0);
        vyy_pos = !r_vyy[W64-1] && (r_vyy != '0);
    end

    // Divider request: signed dividend split into sign and magnitude
    always_comb begin
        div_corr = (r_state == S_CORR_DIV);
        div_dvd  = (r_state == S_ICPT_DIV) ? r_t : r_vxy;
        div_neg  = div_dvd[W64-1];
        div_req.mag = div_neg ? (W64'(0) - div_dvd) : div_dvd;
        case (r_state)
            S_SLOPE_DIV: begin
                div_req.den   = r_vxx;
                div_req.iters = DIV_CNT_W'(W64 + SLOPE_SH);
            end
            S_ICPT_DIV: begin
                div_req.den   = n64 << FRAC_BITS;
                div_req.iters = DIV_CNT_W'(W64 + ICPT_SH);
            end
            default: begin
                div_req.den   = r_t;
                div_req.iters = DIV_CNT_W'(W64 + CORR_DIV_SH);
            end
        endcase
        if (div_corr) begin
            div_req.lim = div_neg ? LIM_NEG16 : LIM_POS16;
        end else begin
            div_req.lim = div_neg ? LIM_NEG32 : LIM_POS32;
        end
        div_res = div_neg ? (QUOT_W'(0) - div_quot) : div_quot;
        sq_val  = ((r_state == S_SQRT_X) ? r_vxx : r_vyy) << CORR_SQ_SH;
    end

    // Multiplier operands and unit select per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sel = 1'b0;
        div_sel = 1'b0;
        sq_sel  = 1'b0;
        case (r_state)
            S_ACC_XX:    begin mul_sel = 1'b1; mul_a = x64;  mul_b = x64;  end
            S_ACC_YY:    begin mul_sel = 1'b1; mul_a = y64;  mul_b = y64;  end
            S_ACC_XY:    begin mul_sel = 1'b1; mul_a = x64;  mul_b = y64;  end
            S_V_XX1:     begin mul_sel = 1'b1; mul_a = sx64; mul_b = sx64; end
            S_V_XX2:     begin mul_sel = 1'b1; mul_a = n64;  mul_b = sxx64; end
            S_V_YY1:     begin mul_sel = 1'b1; mul_a = sy64; mul_b = sy64; end
            S_V_YY2:     begin mul_sel = 1'b1; mul_a = n64;  mul_b = syy64; end
            S_V_XY1:     begin mul_sel = 1'b1; mul_a = sx64; mul_b = sy64; end
            S_V_XY2:     begin mul_sel = 1'b1; mul_a = n64;  mul_b = sxy64; end
            S_ICPT_MUL:  begin mul_sel = 1'b1; mul_a = W64'(r_slope); mul_b = sx64; end
            S_CORR_MUL:  begin mul_sel = 1'b1; mul_a = W64'(r_rx); mul_b = W64'(r_ry); end
            S_SLOPE_DIV,
            S_ICPT_DIV,
            S_CORR_DIV:  div_sel = 1'b1;
            S_SQRT_X,
            S_SQRT_Y:    sq_sel = 1'b1;
            default:     mul_sel = 1'b0;
        endcase
    end

    // Sequencer: next state and register updates
    always_comb begin
        n_state   = r_state;
        n_go      = 1'b0;
        n_cnt     = r_cnt;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_sxx     = r_sxx;
        n_syy     = r_syy;
        n_sxy     = r_sxy;
        n_ovf     = r_ovf;
        n_xs      = r_xs;
        n_ys      = r_ys;
        n_last    = r_last;
        n_t       = r_t;
        n_vxx     = r_vxx;
        n_vyy     = r_vyy;
        n_vxy     = r_vxy;
        n_slope   = r_slope;
        n_icpt    = r_icpt;
        n_corr    = r_corr;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_slope = r_o_slope;
        n_o_icpt  = r_o_icpt;
        n_o_corr  = r_o_corr;
        n_o_cnt   = r_o_cnt;
        n_o_stat  = r_o_stat;
        i_pt.ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_xs   = i_pt.x_sample;
                    n_ys   = i_pt.y_sample;
                    n_last = i_pt.last_point;
                    if (r_cnt < CNT_W'(MAX_POINTS)) begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_sx    = r_sx + SX_W'(i_pt.x_sample);
                        n_sy    = r_sy + SX_W'(i_pt.y_sample);
                        n_state = S_ACC_XX;
                        n_go    = 1'b1;
                    end else begin
                        // point beyond the limit: dropped, flagged
                        n_ovf = 1'b1;
                        if (i_pt.last_point) begin
                            n_state = S_V_XX1;
                            n_go    = 1'b1;
                        end
                    end
                end
            end
            S_ACC_XX: if (mul_done) begin
                n_sxx   = r_sxx + SQ_W'(mul_prod);
                n_state = S_ACC_YY;
                n_go    = 1'b1;
            end
            S_ACC_YY: if (mul_done) begin
                n_syy   = r_syy + SQ_W'(mul_prod);
                n_state = S_ACC_XY;
                n_go    = 1'b1;
            end
            S_ACC_XY: if (mul_done) begin
                n_sxy   = r_sxy + SQ_W'(mul_prod);
                n_state = r_last ? S_V_XX1 : S_IDLE;
                n_go    = r_last;
            end
            // Scaled (co)variances: n*S2 - S1*S1
            S_V_XX1: if (mul_done) begin
                n_t = mul_prod; n_state = S_V_XX2; n_go = 1'b1;
            end
            S_V_XX2: if (mul_done) begin
                n_vxx = mul_prod - r_t; n_state = S_V_YY1; n_go = 1'b1;
            end
            S_V_YY1: if (mul_done) begin
                n_t = mul_prod; n_state = S_V_YY2; n_go = 1'b1;
            end
            S_V_YY2: if (mul_done) begin
                n_vyy = mul_prod - r_t; n_state = S_V_XY1; n_go = 1'b1;
            end
            S_V_XY1: if (mul_done) begin
                n_t = mul_prod; n_state = S_V_XY2; n_go = 1'b1;
            end
            S_V_XY2: if (mul_done) begin
                n_vxy   = mul_prod - r_t;
                n_slope = '0;
                n_state = vxx_pos ? S_SLOPE_DIV : S_ICPT_MUL;
                n_go    = 1'b1;
            end
            S_SLOPE_DIV: if (div_done) begin
                n_slope = div_res; n_state = S_ICPT_MUL; n_go = 1'b1;
            end
            // Intercept numerator uses the clipped slope
            S_ICPT_MUL: if (mul_done) begin
                n_t     = (sy64 << SLOPE_SH) - mul_prod;
                n_state = S_ICPT_DIV;
                n_go    = 1'b1;
            end
            S_ICPT_DIV: if (div_done) begin
                n_icpt = div_res;
                n_corr = '0;
                if (vxx_pos && vyy_pos) begin
                    n_state = S_SQRT_X;
                    n_go    = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SQRT_X: if (sq_done) begin
                n_rx = sq_root; n_state = S_SQRT_Y; n_go = 1'b1;
            end
            S_SQRT_Y: if (sq_done) begin
                n_ry = sq_root; n_state = S_CORR_MUL; n_go = 1'b1;
            end
            S_CORR_MUL: if (mul_done) begin
                n_t = mul_prod; n_state = S_CORR_DIV; n_go = 1'b1;
            end
            S_CORR_DIV: if (div_done) begin
                n_corr = CORR_W'(div_res); n_state = S_FIN;
            end
            // Hand over the result once the output register is free, clear the set
            S_FIN: if (!r_o_valid || o_res.ready) begin
                n_o_valid = 1'b1;
                n_o_slope = r_slope;
                n_o_icpt  = r_icpt;
                n_o_corr  = r_corr;
                n_o_cnt   = r_cnt;
                if (r_ovf) begin
                    n_o_stat = ST_OVERFLOW;
                end else if (!vxx_pos) begin
                    n_o_stat = ST_ZERO_VX;
                end else if (!vyy_pos) begin
                    n_o_stat = ST_ZERO_VY;
                end else begin
                    n_o_stat = ST_OK;
                end
                n_cnt   = '0;
                n_sx    = '0;
                n_sy    = '0;
                n_sxx   = '0;
                n_syy   = '0;
                n_sxy   = '0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_cnt     <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_sxx     <= '0;
            r_syy     <= '0;
            r_sxy     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_go      <= n_go;
            r_cnt     <= n_cnt;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_sxx     <= n_sxx;
            r_syy     <= n_syy;
            r_sxy     <= n_sxy;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_xs      <= n_xs;
        r_ys      <= n_ys;
        r_last    <= n_last;
        r_t       <= n_t;
        r_vxx     <= n_vxx;
        r_vyy     <= n_vyy;
        r_vxy     <= n_vxy;
        r_slope   <= n_slope;
        r_icpt    <= n_icpt;
        r_corr    <= n_corr;
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        r_o_slope <= n_o_slope;
        r_o_icpt  <= n_o_icpt;
        r_o_corr  <= n_o_corr;
        r_o_cnt   <= n_o_cnt;
        r_o_stat  <= n_o_stat;
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.slope       = r_o_slope;
    assign o_res.intercept   = r_o_icpt;
    assign o_res.correlation = r_o_corr;
    assign o_res.point_count = r_o_cnt;
    assign o_res.status      = r_o_stat;

    // A new result only comes out of the closing step
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside closing step");

    // Dropped points only once the set is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_cnt == CNT_W'(MAX_POINTS))
        else $error("overflow flagged below point limit");

    // Zero x variance gives a flat line and no correlation
    a_zero_vx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_stat == ST_ZERO_VX) |-> (r_o_slope == '0 && r_o_corr == '0))
        else $error("zero x variance with non-zero slope or correlation");

    // Only one shared unit finishes at a time
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_done, div_done, sq_done}))
        else $error("two arithmetic units finished together");

endmodule

// ----- tb/sv/linear_regression_correlation_test.sv -----
// linear_regression_correlation_test: self-checking bench for the streaming line fit.
// Depends on lrc_pkg, lrc_if and linear_regression_correlation.
`timescale 1ns / 1ps

module linear_regression_correlation_test;
    import lrc_pkg::*;

    localparam int MAX_PTS   = 1024;
    localparam int FRAC      = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] slope;
        logic [31:0] intercept;
        logic [15:0] correlation;
        logic [10:0] point_count;
        t_status     status;
    } t_fit;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        logic        typed;     // expected result given in the row
        t_fit        fit;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lrc_in_if  #(.SAMPLE_BITS(16)) pt_if ();
    lrc_out_if #(.CNT_W(11))       res_if ();

    linear_regression_correlation #(
        .MAX_POINTS (MAX_PTS),
        .SAMPLE_BITS(16),
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if.sink),
        .o_res  (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Running sums of the open set, kept as 64-bit wrapping words
    logic [10:0] n_acc;
    logic [63:0] sx, sy, sxx, syy, sxy;
    logic        too_many;

    t_fit fits_due[$];
    int   n_errors = 0;
    int   idle_cycles = 0;
    bit   rx_hold = 0;       // long receiver hold-off

    // floor(num * 2^sh / den), clipped to lim, 0 on a zero divisor
    function automatic logic [63:0] udiv_clip(logic [63:0] num, int sh,
                                              logic [63:0] den, logic [63:0] lim);
        logic [127:0] wide;
        logic [127:0] q;
        if (den == 0) return 64'd0;
        wide = {64'd0, num} << sh;
        q = wide / {64'd0, den};
        if (q > {64'd0, lim}) return lim;
        return q[63:0];
    endfunction

    function automatic logic [63:0] sdiv_clip(logic [63:0] u, int sh, logic [63:0] den,
                                              logic [63:0] pos_lim, logic [63:0] neg_lim);
        if (u[63]) return 64'd0 - udiv_clip(64'd0 - u, sh, den, neg_lim);
        return udiv_clip(u, sh, den, pos_lim);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void clear_sums();
        n_acc = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0; too_many = 0;
    endfunction

    // Fold one accepted point in; returns 1 and the fit when the set closes
    function automatic bit fold_point(logic [15:0] x, logic [15:0] y, logic last,
                                      output t_fit fit);
        logic signed [63:0] xs, ys;
        logic [63:0] n, vxx, vyy, vxy, slope, icpt, corr, num;
        xs = {{48{x[15]}}, x};
        ys = {{48{y[15]}}, y};
        fit = '0;
        if (n_acc >= MAX_PTS) begin
            too_many = 1;
        end else begin
            n_acc++;
            sx += xs; sy += ys;
            sxx += xs * xs; syy += ys * ys; sxy += xs * ys;
        end
        if (!last) return 0;
        n = n_acc;
        vxx = n * sxx - sx * sx;
        vyy = n * syy - sy * sy;
        vxy = n * sxy - sx * sy;
        slope = 0;
        corr = 0;
        if ($signed(vxx) > 0)
            slope = sdiv_clip(vxy, 16, vxx, 64'h7FFF_FFFF, 64'h8000_0000);
        num = (sy << 16) - slope * sx;
        icpt = sdiv_clip(num, 0, n << FRAC, 64'h7FFF_FFFF, 64'h8000_0000);
        if ($signed(vxx) > 0 && $signed(vyy) > 0)
            corr = sdiv_clip(vxy, 27, root_floor(vxx << 12) * root_floor(vyy << 12),
                             64'd32767, 64'd32768);
        fit.slope = slope[31:0];
        fit.intercept = icpt[31:0];
        fit.correlation = corr[15:0];
        fit.point_count = n_acc;
        if (too_many) fit.status = ST_OVERFLOW;
        else if ($signed(vxx) <= 0) fit.status = ST_ZERO_VX;
        else if ($signed(vyy) <= 0) fit.status = ST_ZERO_VY;
        else fit.status = ST_OK;
        clear_sums();
        return 1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Send one point and queue its fit, if any; valid stays up after the
    // transaction unless a gap follows
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic last,
                              bit typed = 0, t_fit typed_fit = '0);
        t_fit fit;
        bit   closes;
        int   g;
        g = gap_len();
        if (g > 0) begin
            pt_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.x_sample <= x;
        pt_if.y_sample <= y;
        pt_if.last_point <= last;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        closes = fold_point(x, y, last, fit);
        if (closes) begin
            if (typed && fit != typed_fit) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("typed row disagrees with prediction: %h vs %h", typed_fit, fit);
            end
            fits_due.push_back(typed ? typed_fit : fit);
        end
    endtask

    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fits_due.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, compare each transaction with the oldest fit
    initial begin
        t_fit got;
        t_fit want;
        int   g;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            g = gap_len();
            if (g > 0 || rx_hold) begin
                res_if.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got = {res_if.slope, res_if.intercept, res_if.correlation,
                   res_if.point_count, t_status'(res_if.status)};
            if (fits_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected fit result %h", got);
            end else begin
                want = fits_due.pop_front();
                if (got != want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("fit mismatch: slope %h/%h icpt %h/%h corr %h/%h n %0d/%0d st %0d/%0d",
                                 want.slope, got.slope, want.intercept, got.intercept,
                                 want.correlation, got.correlation, want.point_count,
                                 got.point_count, want.status, got.status);
                end
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("linear_regression_correlation_test: errors");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_row rows[$];
        t_row r;
        int   i, k, len;
        logic [15:0] a, b;
        pt_if.valid = 1'b0;
        pt_if.x_sample = '0;
        pt_if.y_sample = '0;
        pt_if.last_point = 1'b0;
        clear_sums();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single point gives zero x variance, intercept = mean of y
        r = '{16'h0100, 16'h0200, 1'b1, 1'b1,
              '{32'd0, 32'h0002_0000, 16'd0, 11'd1, ST_ZERO_VX}};
        rows.push_back(r);
        // Perfect line y = x: slope one, intercept zero, correlation saturates
        r = '{16'h0000, 16'h0000, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'h0100, 16'h0100, 1'b1, 1'b1,
              '{32'h0001_0000, 32'd0, 16'h7FFF, 11'd2, ST_OK}};
        rows.push_back(r);
        // Constant y: zero y variance
        r = '{16'h0000, 16'h0300, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'h0100, 16'h0300, 1'b1, 1'b1,
              '{32'd0, 32'h0003_0000, 16'd0, 11'd2, ST_ZERO_VY}};
        rows.push_back(r);
        // Extremes of the fields
        r = '{16'h8000, 16'h7FFF, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'h7FFF, 16'h8000, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'hFFFF, 16'h0001, 1'b1, 1'b0, '0}; rows.push_back(r);
        r = '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'h8000, 16'h8000, 1'b1, 1'b0, '0}; rows.push_back(r);
        // Tiny x spread, huge y spread: slope saturates
        r = '{16'h0000, 16'h8000, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'h0001, 16'h7FFF, 1'b1, 1'b0, '0}; rows.push_back(r);
        // Same point twice: zero x variance wins over zero y variance
        r = '{16'h1234, 16'h5678, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{16'h1234, 16'h5678, 1'b1, 1'b0, '0}; rows.push_back(r);
        foreach (rows[j])
            send_point(rows[j].x, rows[j].y, rows[j].last, rows[j].typed, rows[j].fit);

        // Too many points: a full set plus extras, closed by a last point
        for (i = 0; i < MAX_PTS + 3; i++)
            send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       i == MAX_PTS + 2);

        // Sender pause until all fits are back
        wait_drained();

        // Receiver holds off while the sender keeps offering points
        rx_hold = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                rx_hold = 0;
            end
            for (i = 0; i < 12; i++)
                send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           i % 3 == 2);
        join

        // Random sets, mostly short, content near a noisy line
        k = 0;
        while (k < 100) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            b = 16'($urandom_range(0, 65535));
            for (i = 0; i < len; i++) begin
                a = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 3) == 0) b = 16'($urandom_range(0, 65535));
                else b = 16'(a + $urandom_range(0, 255) - 128);
                if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                send_point(a, b, i == len - 1);
                k++;
            end
        end

        wait_drained();
        repeat (500) @(posedge i_clk);
        if (n_errors == 0)
            $display("linear_regression_correlation_test: clean");
        else
            $display("linear_regression_correlation_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/lrc_pkg.sv
hdl/lrc_if.sv
hdl/lrc_mul.sv
hdl/lrc_div.sv
hdl/lrc_sqrt.sv
hdl/linear_regression_correlation.sv
tb/sv/linear_regression_correlation_test.sv
